FILE: hw/rtl/sbfd_pkg.sv
`timescale 1ns / 1ps

package sbfd_pkg;

    // Frame geometry
    localparam int NUM_CHANNELS  = 16;
    localparam int PAYLOAD_BYTES = 23;
    localparam int CHAN_W        = 11;
    localparam int CHAN_BITS     = NUM_CHANNELS * CHAN_W;
    localparam int FLAG_W        = 4;
    localparam int IDX_W         = $clog2(NUM_CHANNELS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;

    // Scaling constants
    localparam logic signed [11:0] RAW_MIN    = 12'sd172;
    localparam logic signed [11:0] RAW_CENTER = 12'sd992;

    // Pulse width: (base*41 + d*25) / 41
    localparam logic signed [17:0] PULSE_BASE_SYM = 18'sd61500;
    localparam logic signed [17:0] PULSE_BASE_ONE = 18'sd41000;
    localparam logic signed [17:0] PULSE_SLOPE    = 18'sd25;
    localparam logic [16:0]        PULSE_DIV      = 17'd41;
    localparam logic [16:0]        PULSE_RECIP    = 17'd102300;   // floor(2^22 / 41)
    localparam int                 PULSE_SHIFT    = 22;

    // Normalised value: |d|*4096/205 (centred) or |d|*2048/205 (one-sided)
    localparam logic [16:0] NORM_DIV   = 17'd205;
    localparam logic [16:0] NORM_RECIP = 17'd81840;               // floor(2^24 / 205)
    localparam int          NORM_SHIFT_SYM = 12;
    localparam int          NORM_SHIFT_ONE = 13;

    localparam logic [11:0] PULSE_MIN = 12'd895;
    localparam logic [11:0] PULSE_MAX = 12'd2143;

    // Output word: channel_index, raw_value, norm_q14, pulse_us, status_flags
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic [FLAG_W-1:0]    flags;
        logic [CHAN_BITS-1:0] chans;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: hw/rtl/sbfd_front.sv
`timescale 1ns / 1ps

module sbfd_front
    import sbfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          push,
    output frame_t        push_frame,
    input  queue_status_t q_status
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_FOOTER  = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    localparam int          COUNT_W   = 5;
    localparam int          STORE_W   = PAYLOAD_BYTES * 8;
    localparam logic [COUNT_W-1:0] LAST_BYTE = COUNT_W'(PAYLOAD_BYTES - 1);

    logic [1:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [STORE_W-1:0] store_reg;
    logic               accept;

    // Only the footer byte needs room in the queue
    assign in_ready = (phase_reg != PH_FOOTER) || !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        push       = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == HEADER_BYTE)
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (count_reg == LAST_BYTE)
                    begin
                        count_next = '0;
                        phase_next = PH_FOOTER;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_FOOTER:
                begin
                    if (in_byte == FOOTER_BYTE)
                    begin
                        push       = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_DISCARD:
                begin
                    if (in_byte == FOOTER_BYTE)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Shift payload bytes in from the top; byte 0 ends up lowest
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_PAYLOAD))
            store_reg <= {in_byte, store_reg[STORE_W-1:8]};
    end

    assign push_frame.chans = store_reg[CHAN_BITS-1:0];
    assign push_frame.flags = store_reg[(PAYLOAD_BYTES-1)*8 +: FLAG_W];

endmodule

FILE: hw/rtl/sbfd_frame_queue.sv
`timescale 1ns / 1ps

module sbfd_frame_queue
    import sbfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_t        push_frame,
    input  logic          pop,
    output frame_t        pop_frame,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t           entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_frame    = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_frame;
    end

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("frame pushed into a full queue");

    no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("frame popped from an empty queue");

endmodule

FILE: hw/rtl/sbfd_back.sv
`timescale 1ns / 1ps

module sbfd_back
    import sbfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  queue_status_t           q_status,
    input  frame_t                  pop_frame,
    output logic                    pop,
    input  logic [NUM_CHANNELS-1:0] sym_mask,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_DATA_W-1:0]   out_data,
    output logic                    out_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // Channel sequencer
    logic                 busy_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CHAN_BITS-1:0] chans_reg;
    logic [FLAG_W-1:0]    flags_reg;
    logic                 advance;
    logic                 issue;

    // Stage 0 logic
    logic [CHAN_W-1:0]    raw0;
    logic                 sym0;
    logic signed [11:0]   d0;
    logic [10:0]          a0;
    logic signed [17:0]   n0;

    // Stage 1
    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [CHAN_W-1:0]    s1_raw_reg;
    logic [10:0]          s1_a_reg;
    logic                 s1_neg_reg;
    logic                 s1_sym_reg;
    logic [16:0]          s1_n_reg;
    logic [FLAG_W-1:0]    s1_flags_reg;
    logic                 s1_last_reg;
    logic [27:0]          pa1;
    logic [33:0]          pp1;

    // Stage 2
    logic                 s2_valid_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic [CHAN_W-1:0]    s2_raw_reg;
    logic [10:0]          s2_a_reg;
    logic                 s2_neg_reg;
    logic                 s2_sym_reg;
    logic [16:0]          s2_n_reg;
    logic [FLAG_W-1:0]    s2_flags_reg;
    logic                 s2_last_reg;
    logic [27:0]          s2_pa_reg;
    logic [33:0]          s2_pp_reg;

    logic [14:0]          qn_est;
    logic [22:0]          norm_num;
    logic [23:0]          rn;
    logic [14:0]          qn;
    logic [15:0]          norm2;
    logic [11:0]          qp_est;
    logic [17:0]          rp;
    logic [11:0]          qp;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    assign advance = !out_valid_reg || out_ready;
    assign issue   = busy_reg && advance;
    assign pop     = !busy_reg && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == LAST_IDX)
                busy_reg <= 1'b0;
        end
    end

    // Advance one channel per issue by shifting the next one down
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chans_reg <= pop_frame.chans;
            flags_reg <= pop_frame.flags;
        end
        else if (issue)
        begin
            chans_reg <= chans_reg >> CHAN_W;
        end
    end

    always_comb
    begin
        raw0 = chans_reg[CHAN_W-1:0];
        sym0 = sym_mask[idx_reg];
        d0   = $signed({1'b0, raw0}) - (sym0 ? RAW_CENTER : RAW_MIN);
        a0   = d0[11] ? 11'(-d0) : 11'(d0);
        n0   = (sym0 ? PULSE_BASE_SYM : PULSE_BASE_ONE) + 18'(d0) * PULSE_SLOPE;
    end

    // Reciprocal products
    assign pa1 = 28'(s1_a_reg) * 28'(NORM_RECIP);
    assign pp1 = 34'(s1_n_reg) * 34'(PULSE_RECIP);

    // Estimates fall short by at most one; correct with a remainder check
    always_comb
    begin
        qn_est   = s2_sym_reg ? 15'(s2_pa_reg >> NORM_SHIFT_SYM)
                              : 15'(s2_pa_reg >> NORM_SHIFT_ONE);
        norm_num = s2_sym_reg ? {s2_a_reg, 12'b0} : {1'b0, s2_a_reg, 11'b0};
        rn       = 24'(norm_num) - 24'(qn_est) * 24'(NORM_DIV);
        qn       = qn_est + ((rn >= 24'(NORM_DIV)) ? 15'd1 : 15'd0);
        norm2    = s2_neg_reg ? -16'(qn) : 16'(qn);
        qp_est   = 12'(s2_pp_reg >> PULSE_SHIFT);
        rp       = 18'(s2_n_reg) - 18'(qp_est) * 18'(PULSE_DIV);
        qp       = qp_est + ((rp >= 18'(PULSE_DIV)) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_idx_reg   <= idx_reg;
            s1_raw_reg   <= raw0;
            s1_a_reg     <= a0;
            s1_neg_reg   <= d0[11];
            s1_sym_reg   <= sym0;
            s1_n_reg     <= n0[16:0];
            s1_flags_reg <= flags_reg;
            s1_last_reg  <= (idx_reg == LAST_IDX);

            s2_idx_reg   <= s1_idx_reg;
            s2_raw_reg   <= s1_raw_reg;
            s2_a_reg     <= s1_a_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_sym_reg   <= s1_sym_reg;
            s2_n_reg     <= s1_n_reg;
            s2_flags_reg <= s1_flags_reg;
            s2_last_reg  <= s1_last_reg;
            s2_pa_reg    <= pa1;
            s2_pp_reg    <= pp1;

            out_data_reg <= {1'b0, s2_flags_reg, qp, norm2, s2_raw_reg, s2_idx_reg};
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    last_on_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_data_reg[IDX_W-1:0] == LAST_IDX))
        else $error("last flag on a channel other than the final one");

    pulse_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[42:31] >= PULSE_MIN)
                          && (out_data_reg[42:31] <= PULSE_MAX))
        else $error("pulse width out of range");

    frame_ends_on_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(idx_reg) == LAST_IDX))
        else $error("channel sequencer stopped early");

endmodule

FILE: hw/rtl/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// A good frame enters the queue with its footer byte; the channel sequencer pops it and each
// channel passes stage 1, stage 2 and the output register. Throughput: one byte per cycle
// at the input; the 16 results of a frame leave on consecutive cycles while the output is
// ready, and no frame is popped until all channels of the last are issued. The input stalls
// only on a footer byte while the two-frame queue is full. Reset (rst_n low, asynchronous):
// parser hunts for a header, queue and pipeline empty, symmetric mask cleared to zero.

module sbus_frame_decoder
    import sbfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,    // [7:0] rx_byte
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,    // [3:0] channel_index, [14:4] raw_value,
                                                     // [30:15] norm_q14, [42:31] pulse_us,
                                                     // [46:43] status_flags, [47] zero
    output logic                    m_axis_tlast,
    // Configuration
    input  logic                    cfg_wr_en,
    input  logic [NUM_CHANNELS-1:0] cfg_wr_data      // symmetric_mask
);

    // Front end: parse bytes, collect payload, hand good frames to the queue.
    // Back end: unpack and scale channels one per cycle while the result stream is
    // ready; meanwhile the front keeps taking bytes of the next frame.

    frame_t                  push_frame;
    frame_t                  pop_frame;
    queue_status_t           q_status;
    logic                    push;
    logic                    pop;
    logic [NUM_CHANNELS-1:0] sym_mask_reg;

    // Hold the scaling mask; the user must write it only while the block is idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sym_mask_reg <= '0;
        else if (cfg_wr_en)
            sym_mask_reg <= cfg_wr_data;
    end

    sbfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_frame (push_frame),
        .q_status   (q_status)
    );

    sbfd_frame_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .status     (q_status)
    );

    sbfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_frame (pop_frame),
        .pop       (pop),
        .sym_mask  (sym_mask_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: tb/sbus_frame_decoder_tb.sv
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;

    import sbfd_pkg::*;

    // Scaling points of the channel conversion
    localparam int MIN_RAW    = 172;
    localparam int CENTRE_RAW = 992;
    localparam int HALF_SPAN  = 820;
    localparam int FULL_SPAN  = 1640;
    localparam int Q14_ONE    = 16384;
    // Pulse width: 500/820 and 1000/1640 both reduce to 25/41
    localparam int US_CENTRE  = 1500;
    localparam int US_FLOOR   = 1000;
    localparam int US_NUM     = 25;
    localparam int US_DEN     = 41;

    localparam int MAX_WAIT     = 14;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {
        SEEK_HEADER,
        TAKE_PAYLOAD,
        CHECK_FOOTER,
        SKIP_FRAME
    } rx_phase_t;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] raw;
        logic signed [15:0] norm;
        logic [11:0]       pulse;
        logic [FLAG_W-1:0] flags;
        logic              last;
    } chan_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;      // [7:0] rx_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;           // [3:0] channel_index, [14:4] raw_value,
                                                     // [30:15] norm_q14, [42:31] pulse_us,
                                                     // [46:43] status_flags, [47] zero
    logic                    m_axis_tlast;
    logic                    cfg_wr_en = 1'b0;
    logic [NUM_CHANNELS-1:0] cfg_wr_data = '0;

    sbus_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Shadow of the decoder: parser phase, payload store and centred-scaling mask
    rx_phase_t         rx_phase = SEEK_HEADER;
    int                payload_count = 0;
    logic [7:0]        frame_buf [PAYLOAD_BYTES];
    logic [NUM_CHANNELS-1:0] centred_mask = '0;

    logic [7:0]        rx_pending [$];     // bytes waiting to be offered
    chan_result_t      chan_expect_q [$];  // channel results still owed by the decoder
    int                mismatch_count = 0;
    int                bytes_queued = 0;

    // Handshake records from the last rising edge, read by the falling-edge drivers
    logic              byte_taken = 1'b0;
    logic              result_taken = 1'b0;

    int                send_gap = 0;
    logic              send_calm = 1'b0;
    int                recv_stall = 0;
    logic              recv_calm = 1'b0;
    chan_result_t      oldest;

    // Unpack a completed frame into its sixteen channel results and queue them
    task automatic expect_channels();
        logic [8*PAYLOAD_BYTES-1:0] payload;
        chan_result_t r;
        int offset;
        int scaled;
        int width_us;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            payload[8*i +: 8] = frame_buf[i];
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            r.idx = IDX_W'(ch);
            r.raw = payload[CHAN_W*ch +: CHAN_W];
            if (centred_mask[ch])
            begin
                offset   = int'(r.raw) - CENTRE_RAW;
                scaled   = (offset * Q14_ONE) / HALF_SPAN;
                width_us = (US_CENTRE * US_DEN + offset * US_NUM) / US_DEN;
            end
            else
            begin
                offset   = int'(r.raw) - MIN_RAW;
                scaled   = (offset * Q14_ONE) / FULL_SPAN;
                width_us = (US_FLOOR * US_DEN + offset * US_NUM) / US_DEN;
            end
            r.norm  = 16'(scaled);
            r.pulse = 12'(width_us);
            // flag byte is the last payload byte; its upper nibble is unused
            r.flags = payload[8*(PAYLOAD_BYTES-1) +: FLAG_W];
            r.last  = (ch == NUM_CHANNELS - 1);
            chan_expect_q.push_back(r);
        end
    endtask

    // Advance the shadow parser by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        case (rx_phase)
            SEEK_HEADER:
            begin
                if (b == HEADER_BYTE)
                begin
                    rx_phase      = TAKE_PAYLOAD;
                    payload_count = 0;
                end
            end
            TAKE_PAYLOAD:
            begin
                // a header value here is plain data
                frame_buf[payload_count] = b;
                payload_count++;
                if (payload_count == PAYLOAD_BYTES)
                begin
                    payload_count = 0;
                    rx_phase      = CHECK_FOOTER;
                end
            end
            CHECK_FOOTER:
            begin
                if (b == FOOTER_BYTE)
                begin
                    rx_phase = SEEK_HEADER;
                    expect_channels();
                end
                else
                    rx_phase = SKIP_FRAME;  // drop the stale frame
            end
            default:
            begin
                if (b == FOOTER_BYTE)
                    rx_phase = SEEK_HEADER;
            end
        endcase
    endtask

    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Monitor: sample both handshakes and the config strobe at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_taken   <= 1'b0;
            result_taken <= 1'b0;
        end
        else
        begin
            byte_taken   <= s_axis_tvalid && s_axis_tready;
            result_taken <= m_axis_tvalid && m_axis_tready;
            if (cfg_wr_en)
                centred_mask = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (chan_expect_q.size() == 0)
                begin
                    $error("channel result %0d arrived with nothing outstanding",
                           m_axis_tdata[3:0]);
                    mismatch_count++;
                end
                else
                begin
                    oldest = chan_expect_q.pop_front();
                    check_field("channel_index", oldest.idx, m_axis_tdata[3:0]);
                    check_field("raw_value", oldest.raw, m_axis_tdata[14:4]);
                    check_field("norm_q14", oldest.norm, $signed(m_axis_tdata[30:15]));
                    check_field("pulse_us", oldest.pulse, m_axis_tdata[42:31]);
                    check_field("status_flags", oldest.flags, m_axis_tdata[46:43]);
                    check_field("last", oldest.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_rx_byte(s_axis_tdata);
        end
    end

    // Byte driver: hold each request until taken, then wait out the drawn gap
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || byte_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                s_axis_tdata  <= rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                // switch now and then between idling and back-to-back bytes
                if ($urandom_range(0, 31) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result sink: draw a fresh stall after every accepted result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_frame(input logic [CHAN_BITS-1:0] chans,
                              input logic [7:0] flag_byte,
                              input logic [7:0] footer);
        logic [8*PAYLOAD_BYTES-1:0] payload;
        payload = {flag_byte, chans};
        send_byte(HEADER_BYTE);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            send_byte(payload[8*i +: 8]);
        send_byte(footer);
    endtask

    // Cycle the scaling end points and the range limits across the channels
    function automatic logic [CHAN_BITS-1:0] extreme_chans(input int shift);
        logic [CHAN_BITS-1:0] v;
        logic [CHAN_W-1:0]    pick;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            case ((k + shift) % 5)
                0:       pick = 11'd0;
                1:       pick = 11'd2047;
                2:       pick = 11'd172;
                3:       pick = 11'd992;
                default: pick = 11'd1811;
            endcase
            v[CHAN_W*k +: CHAN_W] = pick;
        end
        return v;
    endfunction

    // Mostly in the usual stick range, sometimes anywhere in eleven bits
    function automatic logic [CHAN_BITS-1:0] random_chans();
        logic [CHAN_BITS-1:0] v;
        for (int k = 0; k < NUM_CHANNELS; k++)
            v[CHAN_W*k +: CHAN_W] = ($urandom_range(0, 3) == 0) ?
                                    CHAN_W'($urandom_range(0, 2047)) :
                                    CHAN_W'($urandom_range(172, 1811));
        return v;
    endfunction

    task automatic load_mask(input logic [NUM_CHANNELS-1:0] m);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Hold off until every byte is taken and every result is back, then let
    // the pipeline run dry before anything else touches the mask
    task automatic drain_and_settle();
        while (rx_pending.size() != 0 || s_axis_tvalid || chan_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise
    task automatic random_traffic(input int byte_budget);
        int                   start;
        int                   kind;
        logic [7:0]           b;
        logic [CHAN_BITS-1:0] chans;
        start = bytes_queued;
        while (bytes_queued - start < byte_budget)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                6:
                begin
                    // bad footer, junk, then the closing zero
                    send_frame(random_chans(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(1, 255)));
                    send_byte(FOOTER_BYTE);
                end
                7:
                begin
                    // line noise between frames
                    repeat ($urandom_range(1, 6))
                    begin
                        b = $urandom_range(0, 255);
                        if (b == HEADER_BYTE)
                            b = 8'hF0;
                        send_byte(b);
                    end
                end
                8:
                begin
                    // header values buried in the payload
                    chans = random_chans();
                    chans[8*$urandom_range(0, PAYLOAD_BYTES - 2) +: 8] = HEADER_BYTE;
                    chans[8*$urandom_range(0, PAYLOAD_BYTES - 2) +: 8] = HEADER_BYTE;
                    send_frame(chans, 8'($urandom_range(0, 255)), FOOTER_BYTE);
                end
                9:
                begin
                    // cut-off frame: the next frame's bytes fall into its payload
                    send_byte(HEADER_BYTE);
                    repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
                end
                default:
                    send_frame(random_chans(), 8'($urandom_range(0, 255)), FOOTER_BYTE);
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // One-sided scaling everywhere
        load_mask(16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF0);
        send_frame(extreme_chans(0), 8'hF5, FOOTER_BYTE);
        send_frame({(PAYLOAD_BYTES - 1){HEADER_BYTE}}, HEADER_BYTE, FOOTER_BYTE);
        send_frame(extreme_chans(3), 8'h0A, HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'h5A);
        send_byte(FOOTER_BYTE);
        send_frame('0, 8'h00, FOOTER_BYTE);
        drain_and_settle();

        // Centred scaling everywhere
        load_mask(16'hFFFF);
        send_frame(extreme_chans(0), 8'hFA, FOOTER_BYTE);
        drain_and_settle();

        load_mask(16'hAAAA);
        send_frame(extreme_chans(1), 8'h03, FOOTER_BYTE);
        drain_and_settle();

        load_mask(16'($urandom_range(0, 65535)));
        random_traffic(1);
        drain_and_settle();

        load_mask(16'h5555);
        random_traffic(1);
        drain_and_settle();

        load_mask(16'hFFFF);
        random_traffic(1);
        drain_and_settle();

        load_mask(16'($urandom_range(0, 65535)));
        random_traffic(1);
        drain_and_settle();

        if (mismatch_count == 0)
            $display("[sbus_frame_decoder] OK");
        else
            $display("[sbus_frame_decoder] ERROR");
        $finish;
    end

    // Watchdog: a stuck handshake or a missing result ends here
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[sbus_frame_decoder] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sbfd_pkg.sv
hw/rtl/sbfd_front.sv
hw/rtl/sbfd_frame_queue.sv
hw/rtl/sbfd_back.sv
hw/rtl/sbus_frame_decoder.sv
tb/sbus_frame_decoder_tb.sv
